FILE: design/wfn_pkg.sv
`default_nettype none
package wfn_pkg;
    localparam int unsigned MEAN_W  = 32;
    localparam int unsigned M2_W    = 64;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned REQ_NORMALIZE = 0;
    localparam int unsigned REQ_UPDATE    = 1;
    typedef logic [MEAN_W+M2_W-1:0] stat_word_t;
endpackage
`default_nettype wire

FILE: design/wfn_ram.sv
`default_nettype none
module wfn_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: design/welford_feature_normalizer.sv
// Per-feature running z-score normalizer (Welford online mean and variance). Each input
// transaction carries one Q16.16 element and its feature index; req_type 1 first bumps the
// shared sample count (at feature 0) and folds the element into that feature's mean and sum
// of squared deviations, then every transaction returns (x-mean)/sqrt(m2/count+eps) in
// Q16.16, saturated with clipped set, or x itself while the count is below 2 or the index is
// out of range. Statistics live in one synchronous RAM of mean and m2 per feature. One
// transaction at a time is processed, and the time is set by the passes of one shared
// radix-2 unit: a 64-step divide by the count for the mean (updates only), a 64-step divide
// by the count for the variance, a load plus 32 steps of square root and a load plus 64
// steps of divide by the deviation. An update while the count is below 2 runs only the mean
// divide, a normalize-only element with a count below 2 runs none of the passes, and an
// out-of-range element skips the RAM read as well. After reset a clearing pass writes every
// RAM entry, one per cycle, during which input stall stays high.
`default_nettype none
module welford_feature_normalizer #(
    parameter int unsigned FEATURE_COUNT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [5:0]  feature_index,
    input  wire logic signed [31:0] sample_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] normalized_value,
    output logic [5:0]       result_index,
    output logic             clipped
);
    localparam int unsigned AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned SW = wfn_pkg::MEAN_W + wfn_pkg::M2_W;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2, S_MDIV = 4'd3,
        S_MUL = 4'd4, S_WB = 4'd5, S_VDIV = 4'd6, S_SQRT = 4'd7, S_ZDIV = 4'd8,
        S_OUT = 4'd9, S_WAIT = 4'd10;

    logic [3:0]  state_reg;
    logic [AW:0] clr_reg;
    logic        req_reg;
    logic [5:0]  idx_reg;
    logic signed [32:0] x_reg;
    logic [31:0] cnt_reg;
    logic signed [32:0] mean_reg;
    logic [63:0] m2_reg;
    logic [32:0] dmag_reg;
    logic        dneg_reg;
    // shared iterative unit: restoring divider / square root
    logic [63:0] num_reg;     // dividend shifted out / radicand
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [6:0]  step_reg;
    logic [63:0] prod_reg;
    logic signed [31:0] y_reg;
    logic        clip_reg;
    logic        ovalid_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    wfn_pkg::stat_word_t wr_data, rd_data;

    wfn_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stats (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic in_range;
    assign in_range = ({2'b0, feature_index} < 8'(FEATURE_COUNT)) || (FEATURE_COUNT >= 64);
    assign in_stall = (state_reg != S_IDLE);
    assign rd_addr  = AW'(feature_index);
    assign out_valid = ovalid_reg;
    assign normalized_value = y_reg;
    assign result_index = idx_reg;
    assign clipped = clip_reg;

    // one divide step (restoring) and one sqrt step
    logic [64:0] div_trial;
    logic [64:0] div_sh;
    assign div_sh    = {rem_reg[63:0], num_reg[63]};
    assign div_trial = div_sh - {1'b0, den_reg};
    logic [65:0] sq_rem, sq_trial;
    assign sq_rem   = {rem_reg[63:0], num_reg[63:62]};
    assign sq_trial = sq_rem - {quo_reg[63:0], 2'b01};

    logic signed [32:0] mnew;
    logic [32:0] d2mag;
    logic signed [33:0] d2;
    assign mnew  = dneg_reg ? mean_reg - $signed({1'b0, quo_reg[31:0]})
                            : mean_reg + $signed({1'b0, quo_reg[31:0]});
    assign d2    = 34'(x_reg) - 34'(mnew);
    assign d2mag = d2[33] ? 33'(-d2) : 33'(d2);
    logic [64:0] acc;
    assign acc = {1'b0, m2_reg} + {1'b0, prod_reg};

    logic signed [33:0] diff;
    assign diff = 34'(x_reg) - 34'(mean_reg);

    logic accept;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(idx_reg);
        wr_data = {mean_reg[31:0], m2_reg};
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = '0;
        end
        else if (state_reg == S_WB)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            prod_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= req_type;
                        idx_reg <= feature_index;
                        x_reg   <= 33'(sample_value);
                        if (!in_range)
                        begin
                            y_reg    <= sample_value;
                            clip_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (req_type == 1'(wfn_pkg::REQ_UPDATE) && feature_index == 6'd0
                                && cnt_reg != '1)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    mean_reg <= 33'($signed(rd_data[95:64]));
                    m2_reg   <= rd_data[63:0];
                    if (req_reg)
                    begin
                        dneg_reg <= (x_reg - 33'($signed(rd_data[95:64]))) < 0;
                        dmag_reg <= ((x_reg - 33'($signed(rd_data[95:64]))) < 0)
                            ? 33'(-(x_reg - 33'($signed(rd_data[95:64]))))
                            : 33'(x_reg - 33'($signed(rd_data[95:64])));
                        num_reg  <= {31'b0, ((x_reg - 33'($signed(rd_data[95:64]))) < 0)
                            ? 33'(-(x_reg - 33'($signed(rd_data[95:64]))))
                            : 33'(x_reg - 33'($signed(rd_data[95:64])))};
                        den_reg  <= (cnt_reg == '0) ? 64'd1 : {32'b0, cnt_reg};
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        step_reg <= 7'd64;
                        state_reg <= S_MDIV;
                    end
                    else
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_MDIV:
                begin
                    num_reg <= {num_reg[62:0], 1'b0};
                    if (!div_trial[64])
                    begin
                        rem_reg <= div_trial;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == 7'd1)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // 33x33 magnitudes; both always fit 32 bits
                    prod_reg  <= 64'(dmag_reg * d2mag);
                    mean_reg  <= mnew;
                    state_reg <= S_WB;
                    req_reg   <= 1'b0;
                end
                S_WB:
                begin
                    if (req_reg == 1'b0 && state_reg == S_WB && prod_reg != '0)
                    begin
                        m2_reg   <= acc[64] ? '1 : acc[63:0];
                        prod_reg <= '0;
                    end
                    else if (cnt_reg < 32'd2)
                    begin
                        y_reg     <= x_reg[31:0];
                        clip_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        num_reg  <= m2_reg;
                        den_reg  <= {32'b0, cnt_reg};
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        step_reg <= 7'd64;
                        state_reg <= S_VDIV;
                    end
                end
                S_VDIV:
                begin
                    num_reg <= {num_reg[62:0], 1'b0};
                    if (!div_trial[64])
                    begin
                        rem_reg <= div_trial;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (step_reg == 7'd1)
                    begin
                        state_reg <= S_SQRT;
                        step_reg  <= 7'd33;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_SQRT:
                begin
                    if (step_reg == 7'd33)
                    begin
                        // load radicand var+1 (var < 2^64 - 1 always since count >= 2)
                        num_reg  <= quo_reg + 64'd1;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        step_reg <= 7'd32;
                    end
                    else
                    begin
                        num_reg <= {num_reg[61:0], 2'b0};
                        if (!sq_trial[65])
                        begin
                            rem_reg <= {1'b0, sq_trial[63:0]};
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {1'b0, sq_rem[63:0]};
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        if (step_reg == 7'd1)
                        begin
                            state_reg <= S_ZDIV;
                            step_reg  <= 7'd64;
                        end
                        else
                        begin
                            step_reg <= step_reg - 1'b1;
                        end
                    end
                end
                S_ZDIV:
                begin
                    if (step_reg == 7'd64 && den_reg[63:32] != 32'hFFFF_FFFF)
                    begin
                        den_reg  <= {32'hFFFF_FFFF, quo_reg[31:0]};
                        dneg_reg <= diff[33];
                        num_reg  <= 64'((diff[33] ? 50'(-diff) : 50'(diff)) << 16);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                    end
                    else
                    begin
                        num_reg <= {num_reg[62:0], 1'b0};
                        if (div_sh >= {33'b0, den_reg[31:0]})
                        begin
                            rem_reg <= div_sh - {33'b0, den_reg[31:0]};
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= div_sh;
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == 7'd1)
                        begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    if (!dneg_reg)
                    begin
                        clip_reg <= quo_reg > 64'h7FFF_FFFF;
                        y_reg    <= (quo_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                             : $signed(quo_reg[31:0]);
                    end
                    else
                    begin
                        clip_reg <= quo_reg > 64'h8000_0000;
                        y_reg    <= (quo_reg > 64'h8000_0000) ? 32'sh8000_0000
                                                             : $signed(32'(-quo_reg[31:0]));
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (ovalid_reg && !out_stall)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        ovalid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/wfn_checker.sv
`default_nettype none
module wfn_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [31:0] normalized_value,
    input wire logic clipped
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(normalized_value))
        else $error("result dropped under stall");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (normalized_value == 32'h7FFF_FFFF
            || normalized_value == 32'h8000_0000))
        else $error("clipped without saturated value");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");
endmodule

bind welford_feature_normalizer wfn_checker u_wfn_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .normalized_value(normalized_value), .clipped(clipped)
);
`default_nettype wire
